@@ rtl/jsfx_pkg.sv @@
// Shared types, constants and helper functions for the JSON string field extractor.
package jsfx_pkg;

    localparam int KEY_MAX_BYTES   = 8;
    localparam int COUNT_LIMIT_MAX = 131072;
    localparam int CFG_W           = 64;
    localparam int KEY_LEN_W       = 4;
    localparam int CNT_W           = 18;
    localparam int MAX_RES         = 3;

    localparam logic [CNT_W-1:0] CNT_SAT       = 18'h3FFFF;
    localparam logic [CNT_W-1:0] OUT_LIMIT_RST = 18'd131067;

    localparam logic [1:0] CFG_KEY_TEXT   = 2'd0;
    localparam logic [1:0] CFG_KEY_LENGTH = 2'd1;
    localparam logic [1:0] CFG_OUT_LIMIT  = 2'd2;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;

    localparam logic [15:0] CP_EN_DASH = 16'h2013;
    localparam logic [15:0] CP_EM_DASH = 16'h2014;
    localparam logic [15:0] CP_LSQUO   = 16'h2018;
    localparam logic [15:0] CP_RSQUO   = 16'h2019;
    localparam logic [15:0] CP_LDQUO   = 16'h201C;
    localparam logic [15:0] CP_RDQUO   = 16'h201D;
    localparam logic [15:0] CP_ELLIPS  = 16'h2026;

    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_SPACES,
        PH_VALUE,
        PH_ESCAPE,
        PH_HEX,
        PH_SKIP,
        PH_FINISHED
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       out_char;
        logic             char_valid;
        logic             value_done;
        logic             key_found;
        logic [CNT_W-1:0] out_count;
        logic             run_last;
    } t_out_item;

    typedef struct packed {
        t_phase           phase;
        logic [3:0]       match_position;
        logic [15:0]      hex_accumulator;
        logic [2:0]       hex_digits_seen;
        logic [1:0]       skip_remaining;
        logic [CNT_W-1:0] char_count;
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0]     key_text;
        logic [KEY_LEN_W-1:0] key_length;
        logic [CNT_W-1:0]     out_limit;
    } t_cfg;

    function automatic logic [3:0] hex_val(input logic [7:0] h);
        logic [3:0] v;
        v = 4'd0;
        if (h >= 8'h30 && h <= 8'h39) v = 4'(h - 8'h30);
        else if (h >= 8'h61 && h <= 8'h66) v = 4'(h - 8'h57);
        else if (h >= 8'h41 && h <= 8'h46) v = 4'(h - 8'h37);
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                 input logic [1:0] k);
        logic [CNT_W:0] sum;
        sum = {1'b0, c} + (CNT_W+1)'(k);
        return sum[CNT_W] ? CNT_SAT : sum[CNT_W-1:0];
    endfunction

endpackage

@@ rtl/jsfx_decode.sv @@
// Per-byte decode: next scanner state and up to three result transactions.
module jsfx_decode
    import jsfx_pkg::*;
(
    input  t_state                  i_state,
    input  t_cfg                    i_cfg,
    input  t_in_item                i_item,
    output t_state                  o_next,
    output logic [1:0]              o_num,
    output t_out_item [MAX_RES-1:0] o_items
);

    logic [7:0]  b;
    logic [7:0]  expect_ch;
    logic [2:0]  kidx;
    logic [4:0]  pos5;
    logic [4:0]  klen5;
    logic [15:0] acc_n;
    logic [2:0]  seen_n;
    logic [1:0]  skip_n;
    logic [1:0]  n;
    logic [7:0]  chr [MAX_RES];
    logic        found;
    t_state      nx;

    always_comb begin
        b       = i_item.in_byte;
        nx      = i_state;
        n       = 2'd0;
        chr[0]  = 8'd0;
        chr[1]  = 8'd0;
        chr[2]  = 8'd0;
        pos5    = {1'b0, i_state.match_position};
        klen5   = {1'b0, i_cfg.key_length};
        kidx    = 3'(i_state.match_position - 4'd1);
        acc_n   = {i_state.hex_accumulator[11:0], hex_val(b)};
        seen_n  = i_state.hex_digits_seen + 3'd1;
        skip_n  = (i_state.skip_remaining != 2'd0) ? i_state.skip_remaining - 2'd1 : 2'd0;

        if (pos5 == 5'd0) expect_ch = CH_QUOTE;
        else if (pos5 <= klen5) expect_ch = i_cfg.key_text[kidx*8 +: 8];
        else if (pos5 == klen5 + 5'd1) expect_ch = CH_QUOTE;
        else expect_ch = CH_COLON;

        unique case (i_state.phase)
            PH_SEARCH: begin
                if (b == expect_ch) begin
                    if (pos5 >= klen5 + 5'd2) begin
                        nx.phase          = PH_SPACES;
                        nx.match_position = 4'd0;
                    end else begin
                        nx.match_position = i_state.match_position + 4'd1;
                    end
                end else begin
                    nx.match_position = (b == CH_QUOTE) ? 4'd1 : 4'd0;
                end
            end
            PH_SPACES: begin
                if (b == CH_QUOTE) begin
                    nx.phase = PH_VALUE;
                end else if (b != CH_SPACE && b != CH_TAB) begin
                    nx.phase          = PH_SEARCH;
                    nx.match_position = 4'd0;
                end
            end
            PH_VALUE: begin
                priority if (i_state.char_count >= i_cfg.out_limit) begin
                    nx.phase = PH_FINISHED;
                end else if (b == CH_QUOTE) begin
                    nx.phase = PH_FINISHED;
                end else if (b == CH_BSLASH) begin
                    if (i_item.last_byte) begin
                        n      = 2'd1;
                        chr[0] = CH_BSLASH;
                    end else begin
                        nx.phase = PH_ESCAPE;
                    end
                end else if (b < UTF8_CONT) begin
                    n      = 2'd1;
                    chr[0] = b;
                end else if (b >= UTF8_LEAD4) begin
                    nx.skip_remaining = 2'd3;
                    nx.phase          = PH_SKIP;
                end else if (b >= UTF8_LEAD3) begin
                    nx.skip_remaining = 2'd2;
                    nx.phase          = PH_SKIP;
                end else if (b >= UTF8_LEAD2) begin
                    nx.skip_remaining = 2'd1;
                    nx.phase          = PH_SKIP;
                end else begin
                    // stray continuation byte: dropped
                end
            end
            PH_ESCAPE: begin
                nx.phase = PH_VALUE;
                unique case (b)
                    CH_LC_N: begin
                        n      = 2'd1;
                        chr[0] = CH_NL;
                    end
                    CH_LC_T: begin
                        n      = 2'd1;
                        chr[0] = CH_TAB;
                    end
                    CH_LC_R: ;
                    CH_LC_U: begin
                        nx.hex_accumulator = 16'd0;
                        nx.hex_digits_seen = 3'd0;
                        nx.phase           = PH_HEX;
                    end
                    default: begin
                        n      = 2'd1;
                        chr[0] = b;
                    end
                endcase
            end
            PH_HEX: begin
                nx.hex_accumulator = acc_n;
                nx.hex_digits_seen = seen_n;
                if (seen_n >= 3'd4) begin
                    nx.phase           = PH_VALUE;
                    nx.hex_digits_seen = 3'd0;
                    n                  = 2'd1;
                    priority if (acc_n < 16'd128) begin
                        chr[0] = acc_n[7:0];
                    end else if (acc_n == CP_EN_DASH || acc_n == CP_EM_DASH) begin
                        chr[0] = CH_DASH;
                    end else if (acc_n == CP_LSQUO || acc_n == CP_RSQUO) begin
                        chr[0] = CH_APOS;
                    end else if (acc_n == CP_LDQUO || acc_n == CP_RDQUO) begin
                        chr[0] = CH_QUOTE;
                    end else if (acc_n == CP_ELLIPS) begin
                        n      = 2'd3;
                        chr[0] = CH_DOT;
                        chr[1] = CH_DOT;
                        chr[2] = CH_DOT;
                    end else begin
                        chr[0] = CH_QMARK;
                    end
                end
            end
            PH_SKIP: begin
                nx.skip_remaining = skip_n;
                if (skip_n == 2'd0) nx.phase = PH_VALUE;
            end
            default: ;
        endcase

        nx.char_count = sat_add(i_state.char_count, n);
        found = (nx.phase != PH_SEARCH) && (nx.phase != PH_SPACES);

        for (int k = 0; k < MAX_RES; k++) begin
            o_items[k].out_char   = chr[k];
            o_items[k].char_valid = 1'b1;
            o_items[k].value_done = (2'(k) == n - 2'd1) && i_item.last_byte;
            o_items[k].key_found  = found;
            o_items[k].out_count  = sat_add(i_state.char_count, 2'(k + 1));
            o_items[k].run_last   = (2'(k) == n - 2'd1);
        end
        o_num = n;

        // stream end without a character still reports completion
        if (n == 2'd0 && i_item.last_byte) begin
            o_items[0].out_char   = 8'd0;
            o_items[0].char_valid = 1'b0;
            o_items[0].value_done = 1'b1;
            o_items[0].key_found  = found;
            o_items[0].out_count  = nx.char_count;
            o_items[0].run_last   = 1'b1;
            o_num                 = 2'd1;
        end

        if (i_item.last_byte) begin
            o_next = '{phase: PH_SEARCH, match_position: 4'd0, hex_accumulator: 16'd0,
                       hex_digits_seen: 3'd0, skip_remaining: 2'd0,
                       char_count: {CNT_W{1'b0}}};
        end else begin
            o_next = nx;
        end
    end

endmodule

@@ rtl/jsfx_obuf.sv @@
// Result buffer: up to three transactions, drained one per cycle unless stalled.
module jsfx_obuf
    import jsfx_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic [1:0]              i_num,
    input  t_out_item [MAX_RES-1:0] i_items,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output t_out_item               o_out_data,
    output logic                    o_free
);

    t_out_item  r_items [MAX_RES];
    logic [1:0] r_num;
    logic [1:0] r_idx;
    logic       take;
    logic       at_end;

    assign o_out_valid = (r_num != 2'd0);
    assign o_out_data  = r_items[r_idx];
    assign take        = o_out_valid && !i_out_stall;
    assign at_end      = (r_idx == r_num - 2'd1);
    assign o_free      = !o_out_valid || (take && at_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_num <= i_num;
            r_idx <= 2'd0;
        end else if (take) begin
            if (at_end) begin
                r_num <= 2'd0;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < MAX_RES; k++) begin
                r_items[k] <= i_items[k];
            end
        end
    end

endmodule

@@ rtl/json_string_field_extractor.sv @@
// Top level of the JSON string field extractor: configuration, scanner state, result buffer.
//
// One JSON byte is taken per cycle unless stalled. It is decoded in the cycle of acceptance
// and the results land in a three-entry result register, visible from the next cycle on.
// With the output side not stalling, a byte that gives k results (1 for most value bytes, 3
// for an ellipsis, 0 outside the value but for the last byte) keeps the input stalled until
// the result register, draining one transaction per cycle, shows its last. While the output
// side stalls a held result transaction, the input is stalled too, whatever the next byte
// would give. Configuration writes take effect at once and are meant for idle periods only.
module json_string_field_extractor
    import jsfx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);

    t_cfg                    r_cfg;
    t_state                  r_state;
    t_state                  n_state;
    logic [1:0]              num;
    t_out_item [MAX_RES-1:0] items;
    logic                    free;
    logic                    accept;
    logic [KEY_LEN_W-1:0]    klen_w;
    logic [CNT_W-1:0]        lim_w;

    assign o_in_stall = !free;
    assign accept     = i_in_valid && free;

    assign klen_w = i_cfg_wdata[KEY_LEN_W-1:0];
    assign lim_w  = i_cfg_wdata[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_text   <= {CFG_W{1'b0}};
            r_cfg.key_length <= {KEY_LEN_W{1'b0}};
            r_cfg.out_limit  <= OUT_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_TEXT: r_cfg.key_text <= i_cfg_wdata;
                CFG_KEY_LENGTH: begin
                    r_cfg.key_length <= (32'(klen_w) > KEY_MAX_BYTES) ?
                                        KEY_LEN_W'(KEY_MAX_BYTES) : klen_w;
                end
                CFG_OUT_LIMIT: begin
                    r_cfg.out_limit <= (32'(lim_w) > COUNT_LIMIT_MAX) ?
                                       CNT_W'(COUNT_LIMIT_MAX) : lim_w;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_SEARCH, match_position: 4'd0, hex_accumulator: 16'd0,
                         hex_digits_seen: 3'd0, skip_remaining: 2'd0,
                         char_count: {CNT_W{1'b0}}};
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    jsfx_decode u_decode (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (i_in_data),
        .o_next  (n_state),
        .o_num   (num),
        .o_items (items)
    );

    jsfx_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && (num != 2'd0)),
        .i_num       (num),
        .i_items     (items),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_free      (free)
    );

endmodule

@@ rtl/jsfx_chk.sv @@
// Port-level checker for the JSON string field extractor, bound to the top level.
module jsfx_chk
    import jsfx_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transaction changed");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.value_done |-> o_out_data.run_last)
        else $error("value_done without run_last");

    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.char_valid |->
            o_out_data.value_done && o_out_data.run_last && (o_out_data.out_char == 8'd0))
        else $error("empty result is not a completion report");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result buffer");

endmodule

bind json_string_field_extractor jsfx_chk u_jsfx_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
